### hw/rtl/supercap_pulse_current_planner_assert.svh
// assertion macros for the supercap pulse current planner
`ifndef SUPERCAP_PULSE_CURRENT_PLANNER_ASSERT_SVH
`define SUPERCAP_PULSE_CURRENT_PLANNER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SPCP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spcp assertion failed (same cycle)");

// next-cycle implication, sampled on clk, off while rst is high
`define SPCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spcp assertion failed (next cycle)");

`endif

### hw/rtl/spcp_pkg.sv
// shared types and constants of the supercap pulse current planner
`timescale 1ns / 1ps

package spcp_pkg;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 48;

  localparam int TICK_W   = 32;
  localparam int VOLT_W   = 16;
  localparam int CAP_W    = 16;
  localparam int PERIOD_W = 32;
  localparam int TARGET_W = 48;
  localparam int CMD_W    = 32;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_DECISION_PERIOD    = 3'd0,
    REG_ENERGY_TARGET_HIGH = 3'd1,
    REG_ENERGY_TARGET_LOW  = 3'd2,
    REG_HIGH_PHASE_LENGTH  = 3'd3,
    REG_LOW_PHASE_LENGTH   = 3'd4,
    REG_CAPACITANCE        = 3'd5
  } spcp_reg_t;

  localparam logic [PERIOD_W-1:0] RST_DECISION_PERIOD    = 32'hFFFF_FFFF;
  localparam logic [TARGET_W-1:0] RST_ENERGY_TARGET_HIGH = 48'd80000000000;
  localparam logic [TARGET_W-1:0] RST_ENERGY_TARGET_LOW  = 48'd10000000000;
  localparam logic [PERIOD_W-1:0] RST_HIGH_PHASE_LENGTH  = 32'd10;
  localparam logic [PERIOD_W-1:0] RST_LOW_PHASE_LENGTH   = 32'd20;
  localparam logic [CAP_W-1:0]    RST_CAPACITANCE        = 16'd1000;
  localparam int                  RST_PHASE_END          = 20;

  localparam logic [CMD_W-1:0] CMD_MAX = 32'h7FFF_FFFF;
  localparam logic [CMD_W-1:0] CMD_MIN = 32'h8000_0000;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } spcp_unit_status_t;

endpackage

### hw/rtl/spcp_if.sv
// valid/ready channel interfaces of the supercap pulse current planner
`timescale 1ns / 1ps

interface spcp_cfg_if import spcp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] reg_index;
  logic [CFG_DATA_WIDTH-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

interface spcp_in_if import spcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] now_tick;
  logic [VOLT_W-1:0] cap_voltage;
  logic [VOLT_W-1:0] bus_voltage;

  modport source (output valid, output now_tick, output cap_voltage, output bus_voltage,
                  input ready);
  modport sink   (input valid, input now_tick, input cap_voltage, input bus_voltage,
                  output ready);
endinterface

interface spcp_out_if import spcp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    high_demand;
  logic signed [CMD_W-1:0] current_command;
  logic                    divide_fault;

  modport source (output valid, output high_demand, output current_command,
                  output divide_fault, input ready);
  modport sink   (input valid, input high_demand, input current_command,
                  input divide_fault, output ready);
endinterface

### hw/rtl/supercap_pulse_current_planner.sv
// supercap pulse current planner: top level, sequencer and configuration registers
`timescale 1ns / 1ps
`include "supercap_pulse_current_planner_assert.svh"

// Takes one time sample at a time (now_tick, cap_voltage, bus_voltage). A sample
// whose now_tick has not yet reached the next decision time, or that arrives once
// the decision time has saturated at all ones ("never"), gives no result and frees
// the block straight from the check state. A decision sample advances the decision
// time by decision_period, switches between the low-demand and high-demand phase
// when the phase end is reached, computes the stored energy C*V^2/2 in nanojoules
// and gives one result: the phase, a saturated signed current command and a fault
// flag. On its way to the output register a decision sample passes the check and
// advance states, two passes through the one bit per cycle shift-add multiplier
// (C*V, then *V), the difference and magnitude states, two passes through the one
// bit per cycle restoring divider (by bus voltage, then by remaining phase time)
// and the saturation state; a faulted decision skips the divider. One sample is
// in work at a time: sample.ready is high only while the sequencer is idle. The
// output register holds a finished result until it is taken, and the next sample
// is accepted meanwhile. Configuration writes are always accepted (cfg.ready is
// tied high) and must be issued only while the block is idle; indexes above the
// register list are ignored. TIME_WIDTH sets the width of the internal time
// state, and ENERGY_WIDTH the width that energy and targets saturate to.
module supercap_pulse_current_planner import spcp_pkg::*; #(
  parameter int TIME_WIDTH   = 32,
  parameter int ENERGY_WIDTH = 48
) (
  input  logic      clk,
  input  logic      rst,
  spcp_cfg_if.sink  cfg,
  spcp_in_if.sink   sample,
  spcp_out_if.source result
);

  localparam int TW     = TIME_WIDTH;
  localparam int EW     = ENERGY_WIDTH;
  localparam int MUL_AW = CAP_W + VOLT_W;
  localparam int MUL_BW = VOLT_W;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam logic [63:0] EMAX64 = {64{1'b1}} >> (64 - ENERGY_WIDTH);

  // sequencer states, one-hot
  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHECK = 11'b000_0000_0010,
    S_ADV   = 11'b000_0000_0100,
    S_MUL1  = 11'b000_0000_1000,
    S_MUL2  = 11'b000_0001_0000,
    S_DIFF  = 11'b000_0010_0000,
    S_MAG   = 11'b000_0100_0000,
    S_DIV1  = 11'b000_1000_0000,
    S_DIV2  = 11'b001_0000_0000,
    S_SAT   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [PERIOD_W-1:0] cfg_period;
  logic [TARGET_W-1:0] cfg_tgt_high;
  logic [TARGET_W-1:0] cfg_tgt_low;
  logic [PERIOD_W-1:0] cfg_len_high;
  logic [PERIOD_W-1:0] cfg_len_low;
  logic [CAP_W-1:0]    cfg_cap;

  // planner state
  logic [TW-1:0] next_decision_time;
  logic [TW-1:0] phase_end_time;
  logic          phase_is_high;

  // per-sample working registers
  logic [TW-1:0]     now_r;
  logic [VOLT_W-1:0] volt_r;
  logic [VOLT_W-1:0] bus_r;
  logic              ph_end_r;
  logic              fault_r;
  logic [TW-1:0]     rem_r;
  logic [EW-1:0]     energy_r;
  logic [EW-1:0]     tgt_r;
  logic [EW:0]       diff_r;
  logic              neg_r;
  logic [EW-1:0]     mag_r;
  logic [CMD_W-1:0]  cmd_r;

  // output register
  logic             res_valid;
  logic             res_high;
  logic [CMD_W-1:0] res_cmd;
  logic             res_fault;

  // serial units
  logic              mul_start;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_PW-1:0] mul_prod;
  spcp_unit_status_t mul_st;
  logic              div_start;
  logic [EW-1:0]     div_dividend;
  logic [TW-1:0]     div_divisor;
  logic [EW-1:0]     div_quot;
  spcp_unit_status_t div_st;

  logic              decide;
  logic [63:0]       energy_wide;
  logic [63:0]       tgt_wide;
  logic [EW-1:0]     energy_sat;
  logic [EW-1:0]     tgt_sat;
  logic [EW-1:0]     sub_x;
  logic [EW-1:0]     sub_y;
  logic [EW-1:0]     mag_calc;
  logic [CMD_W-1:0]  cmd_calc;
  logic              out_load;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_period   <= RST_DECISION_PERIOD;
      cfg_tgt_high <= RST_ENERGY_TARGET_HIGH;
      cfg_tgt_low  <= RST_ENERGY_TARGET_LOW;
      cfg_len_high <= RST_HIGH_PHASE_LENGTH;
      cfg_len_low  <= RST_LOW_PHASE_LENGTH;
      cfg_cap      <= RST_CAPACITANCE;
    end else if (cfg.valid) begin
      case (spcp_reg_t'(cfg.reg_index))
        REG_DECISION_PERIOD:    cfg_period   <= cfg.wdata[PERIOD_W-1:0];
        REG_ENERGY_TARGET_HIGH: cfg_tgt_high <= cfg.wdata[TARGET_W-1:0];
        REG_ENERGY_TARGET_LOW:  cfg_tgt_low  <= cfg.wdata[TARGET_W-1:0];
        REG_HIGH_PHASE_LENGTH:  cfg_len_high <= cfg.wdata[PERIOD_W-1:0];
        REG_LOW_PHASE_LENGTH:   cfg_len_low  <= cfg.wdata[PERIOD_W-1:0];
        REG_CAPACITANCE:        cfg_cap      <= cfg.wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // decision test: the saturated all-ones time means never
  assign decide = (next_decision_time != {TW{1'b1}}) && (now_r >= next_decision_time);

  // energy = C*V*V/2, clipped to the energy width
  assign energy_wide = 64'(mul_prod[MUL_PW-1:1]);
  assign energy_sat  = (energy_wide > EMAX64) ? EMAX64[EW-1:0] : energy_wide[EW-1:0];
  assign tgt_wide    = 64'(phase_is_high ? cfg_tgt_low : cfg_tgt_high);
  assign tgt_sat     = (tgt_wide > EMAX64) ? EMAX64[EW-1:0] : tgt_wide[EW-1:0];

  // high demand: energy - low target; low demand: high target - energy
  assign sub_x    = phase_is_high ? energy_r : tgt_r;
  assign sub_y    = phase_is_high ? tgt_r : energy_r;
  assign mag_calc = diff_r[EW] ? (EW'(0) - diff_r[EW-1:0]) : diff_r[EW-1:0];

  // command saturation; a fault gives the rail that matches the sign, or zero when the magnitude is zero
  always_comb begin
    if (fault_r) begin
      if (mag_r == '0) begin
        cmd_calc = '0;
      end else begin
        cmd_calc = neg_r ? CMD_MIN : CMD_MAX;
      end
    end else if (neg_r) begin
      cmd_calc = (div_quot > EW'(CMD_MIN)) ? CMD_MIN : (CMD_W'(0) - div_quot[CMD_W-1:0]);
    end else begin
      cmd_calc = (div_quot > EW'(CMD_MAX)) ? CMD_MAX : div_quot[CMD_W-1:0];
    end
  end

  // serial unit hookup: the multiplier runs C*V, then (C*V)*V
  assign mul_start    = (state == S_ADV) || ((state == S_MUL1) && mul_st.done);
  assign mul_a        = (state == S_MUL1) ? mul_prod[MUL_AW-1:0] : MUL_AW'(cfg_cap);
  assign div_start    = ((state == S_MAG) && !fault_r) || ((state == S_DIV1) && div_st.done);
  assign div_dividend = (state == S_DIV1) ? div_quot : mag_calc;
  assign div_divisor  = (state == S_DIV1) ? rem_r : TW'(bus_r);

  spcp_mul #(
    .AW (MUL_AW),
    .BW (MUL_BW)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (volt_r),
    .prod   (mul_prod),
    .status (mul_st)
  );

  spcp_div #(
    .NW (EW),
    .DW (TW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .status   (div_st)
  );

  // output slot is free when empty or being taken this cycle
  assign out_load = (state == S_OUT) && (!res_valid || result.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (sample.valid) state_next = S_CHECK;
      S_CHECK: state_next = decide ? S_ADV : S_IDLE;
      S_ADV:   state_next = S_MUL1;
      S_MUL1:  if (mul_st.done) state_next = S_MUL2;
      S_MUL2:  if (mul_st.done) state_next = S_DIFF;
      S_DIFF:  state_next = S_MAG;
      S_MAG:   state_next = fault_r ? S_SAT : S_DIV1;
      S_DIV1:  if (div_st.done) state_next = S_DIV2;
      S_DIV2:  if (div_st.done) state_next = S_SAT;
      S_SAT:   state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      next_decision_time <= '0;
      phase_end_time     <= TW'(RST_PHASE_END);
      phase_is_high      <= 1'b0;
      res_valid          <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ADV) begin
        next_decision_time <= sat_add(next_decision_time, TW'(cfg_period));
        if (ph_end_r) begin
          phase_end_time <= sat_add(phase_end_time,
                                    phase_is_high ? TW'(cfg_len_low) : TW'(cfg_len_high));
          phase_is_high  <= !phase_is_high;
        end
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && sample.valid) begin
      now_r  <= TW'(sample.now_tick);
      volt_r <= sample.cap_voltage;
      bus_r  <= sample.bus_voltage;
    end
    if (state == S_CHECK) begin
      ph_end_r <= now_r >= phase_end_time;
    end
    // phase end is final from here on
    if (state == S_MUL1) begin
      fault_r <= (bus_r == '0) || (phase_end_time <= now_r);
      rem_r   <= phase_end_time - now_r;
    end
    if ((state == S_MUL2) && mul_st.done) begin
      energy_r <= energy_sat;
      tgt_r    <= tgt_sat;
    end
    if (state == S_DIFF) begin
      diff_r <= {1'b0, sub_x} - {1'b0, sub_y};
    end
    if (state == S_MAG) begin
      neg_r <= diff_r[EW];
      mag_r <= mag_calc;
    end
    if (state == S_SAT) begin
      cmd_r <= cmd_calc;
    end
    if (out_load) begin
      res_high  <= phase_is_high;
      res_cmd   <= cmd_r;
      res_fault <= fault_r;
    end
  end

  assign sample.ready           = (state == S_IDLE);
  assign result.valid           = res_valid;
  assign result.high_demand     = res_high;
  assign result.current_command = res_cmd;
  assign result.divide_fault    = res_fault;

  // a serial unit is only started once its previous pass is over
  `SPCP_ASSERT_SAME(a_mul_start_free, mul_start, !mul_st.busy)
  `SPCP_ASSERT_SAME(a_div_start_free, div_start, !div_st.busy)
  // a new sample never lands while arithmetic is still running
  `SPCP_ASSERT_SAME(a_accept_units_idle, sample.valid && sample.ready, !mul_st.busy && !div_st.busy)
  // phase state moves only in the advance step
  `SPCP_ASSERT_NEXT(a_phase_end_hold, state != S_ADV, $stable(phase_end_time) && $stable(phase_is_high))

endmodule

### hw/rtl/spcp_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module spcp_mul import spcp_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic [AW+BW-1:0]   prod,
  output spcp_unit_status_t  status
);

  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc;
  logic [AW-1:0]    mcand;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [AW:0]      upper_sum;

  // add the multiplicand into the upper half when the low bit is set
  assign upper_sum = {1'b0, acc[AW+BW-1:BW]} + (acc[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= {{AW{1'b0}}, b};
      mcand <= a;
    end else if (busy) begin
      acc <= {upper_sum, acc[BW-1:1]};
    end
  end

  assign prod        = acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule

### hw/rtl/spcp_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module spcp_div import spcp_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NW-1:0]     dividend,
  input  logic [DW-1:0]     divisor,
  output logic [NW-1:0]     quotient,
  output spcp_unit_status_t status
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [DW-1:0] rmd;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   rmd_sh;
  logic [DW+1:0] trial;
  logic          fits;

  assign rmd_sh = {rmd, quo[NW-1]};
  assign trial  = {1'b0, rmd_sh} - {2'b00, dvs};
  assign fits   = !trial[DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rmd <= '0;
      dvs <= divisor;
    end else if (busy) begin
      // partial remainder stays below the divisor, so DW bits hold it
      rmd <= fits ? trial[DW-1:0] : rmd_sh[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule
